/* rtl/fps_pkg.sv */
// fps_pkg: widths, register indexes, mode codes and shared structs for the
// frame pacer with skip. No dependencies; every rtl file imports it.
package fps_pkg;

    // Field and state widths
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 20;
    localparam int SKIP_W     = 3;
    localparam int MAX_SKIP   = 4;
    localparam int Q_W        = SKIP_W + 1;    // saturating quotient, holds up to 2*MAX_SKIP+1
    localparam int CNT_W      = $clog2(TIME_W);
    localparam int SPEED_W    = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLACED = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16);

    // Speed codes (unused code acts as normal)
    localparam logic [SPEED_W-1:0] SPD_SLOW = 2'd1;
    localparam logic [SPEED_W-1:0] SPD_FAST = 2'd2;

    // Skip mode codes (unused code acts as half mode)
    localparam logic [MODE_W-1:0] SKIP_OFF = 2'd0;
    localparam logic [MODE_W-1:0] SKIP_STD = 2'd1;

    // End-of-pass flags from the serial timing unit
    typedef struct packed {
        logic late_path;    // elapsed beyond budget, or timer wrapped
        logic wrapped;      // now below reference
        logic over_period;  // lateness above one period
        logic end_wrap;     // wait end ran past the wrap point
    } fps_time_flags_t;

    // Threshold selection for the skip unit
    typedef struct packed {
        logic std_mode;
        logic interlaced;
    } fps_skip_sel_t;

    // Threshold compare results from the skip unit
    typedef struct packed {
        logic ge;
        logic gt;
    } fps_cmp_flags_t;

endpackage

/* rtl/frame_pacer_with_skip.sv */
// frame_pacer_with_skip: top level. Sequencer, pacing state, configuration
// registers and output register; uses fps_pkg, fps_time_unit, fps_skip_unit.
//
// One item per frame-end event, one result per item. A reference reset or a
// fast-mode item met while skipping goes from acceptance straight to the finish
// state; any other item first passes through the skip decision state.
// A limited or slow-mode item adds one pass of the serial timing unit
// (32 shifts and a done strobe), and a skip evaluation adds one pass of
// the bit-serial divider; both serial passes run over the 32-bit timer word.
// The next item is accepted while a result waits in the output register; a
// finished result waits for that register to free.
// Configuration is taken at any time on its own channel and must only be
// written while no item is in flight.
module frame_pacer_with_skip (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fps_pkg::TIME_W-1:0]      s_now_ticks,
    input  logic                            s_limited,
    input  logic [fps_pkg::SPEED_W-1:0]     s_speed,
    input  logic                            s_odd_field,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fps_pkg::TIME_W-1:0]      m_release_time,
    output logic                            m_must_wait,
    output logic [fps_pkg::SKIP_W-1:0]      m_periods_to_skip,
    output logic [fps_pkg::TIME_W-1:0]      m_lateness
);
    import fps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TIME = 5'b00010,
        ST_DEC  = 5'b00100,
        ST_EVAL = 5'b01000,
        ST_FIN  = 5'b10000
    } fps_state_t;

    fps_state_t state_reg;

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [MODE_W-1:0]   skip_mode_reg;
    logic                interlaced_reg;

    // pacing state
    logic [TIME_W-1:0] ref_time_reg, wait_budget_reg, late_amount_reg;
    logic [SKIP_W-1:0] skip_count_reg;
    logic [1:0]        fast_phase_reg;
    logic              reset_pending_reg;

    // per-item work registers
    logic [TIME_W-1:0] release_reg, lat_reg;
    logic              wait_reg, limited_reg, odd_reg;

    // output register
    logic              m_valid_reg, m_wait_reg;
    logic [TIME_W-1:0] m_release_reg, m_lat_reg;
    logic [SKIP_W-1:0] m_skip_reg;

    // unit connections
    logic              tu_start, tu_done;
    logic [TIME_W-1:0] tu_sum, tu_late, tu_pml, tu_end;
    fps_time_flags_t   tu_flags;
    logic              su_start, su_done;
    logic [Q_W-1:0]    su_quo;
    logic [PERIOD_W-1:0] su_rem;
    fps_skip_sel_t     su_sel;
    fps_cmp_flags_t    su_cmp;

    logic              accept, is_fast, is_slow, fast_skipping, out_free, wait_end_wrap;
    logic [1:0]        phase_inc;
    logic [TIME_W-1:0] wait_end;
    logic [SKIP_W-1:0] skip_eval;
    logic [Q_W-1:0]    q_int, q_std;
    logic [PERIOD_W+4:0] rem20, per17;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // item classification at acceptance
    always_comb begin
        is_fast = (s_speed == SPD_FAST);
        is_slow = (s_speed == SPD_SLOW);
        phase_inc = fast_phase_reg + 2'd1;
        fast_skipping = is_fast && (skip_count_reg != '0);
        tu_start = accept && !reset_pending_reg && !fast_skipping && (s_limited || is_slow);
        su_start = (state_reg == ST_DEC) && (skip_count_reg == '0)
                   && (skip_mode_reg != SKIP_OFF);
        su_sel.std_mode   = (skip_mode_reg == SKIP_STD);
        su_sel.interlaced = interlaced_reg;
        wait_end_wrap = tu_flags.end_wrap;
        wait_end = wait_end_wrap ? '0 : tu_end;
    end

    // skip count from the divider result
    always_comb begin
        rem20 = ({5'b00000, su_rem} << 4) + ({5'b00000, su_rem} << 2);
        per17 = ({5'b00000, period_reg} << 4) + {5'b00000, period_reg};
        // interlaced: rounded up to even, capped
        if (su_quo > Q_W'(MAX_SKIP)) begin
            q_int = Q_W'(MAX_SKIP);
        end else if (su_quo[0]) begin
            q_int = su_quo + 1'b1;
        end else begin
            q_int = su_quo;
        end
        // progressive: quotient plus 0.15, floored, capped
        if (su_quo >= Q_W'(MAX_SKIP)) begin
            q_std = Q_W'(MAX_SKIP - 1);
        end else begin
            q_std = (rem20 >= per17) ? su_quo + 1'b1 : su_quo;
            if (q_std >= Q_W'(MAX_SKIP)) begin
                q_std = Q_W'(MAX_SKIP - 1);
            end
        end
        skip_eval = skip_count_reg;
        if (su_sel.std_mode) begin
            if (su_cmp.ge) begin
                if (interlaced_reg) begin
                    if (!odd_reg) begin
                        skip_eval = q_int[SKIP_W-1:0];
                    end
                end else begin
                    skip_eval = q_std[SKIP_W-1:0];
                end
            end
        end else if (interlaced_reg) begin
            if (su_cmp.gt && !odd_reg) begin
                skip_eval = SKIP_W'(2);
            end
        end else if (su_cmp.gt) begin
            skip_eval = SKIP_W'(1);
        end
    end

    // sequencer, pacing state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            period_reg        <= PERIOD_RESET;
            skip_mode_reg     <= SKIP_OFF;
            interlaced_reg    <= 1'b0;
            ref_time_reg      <= '0;
            wait_budget_reg   <= '0;
            late_amount_reg   <= '0;
            skip_count_reg    <= '0;
            fast_phase_reg    <= '0;
            reset_pending_reg <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            // output valid: set on finish, dropped when taken
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (reset_pending_reg) begin
                            // take the reference, no wait
                            reset_pending_reg <= 1'b0;
                            ref_time_reg      <= s_now_ticks;
                            late_amount_reg   <= '0;
                            wait_budget_reg   <= '0;
                            state_reg         <= ST_FIN;
                        end else if (fast_skipping) begin
                            fast_phase_reg <= phase_inc;
                            skip_count_reg <= (phase_inc != 2'd0) ? SKIP_W'(1) : '0;
                            state_reg      <= ST_FIN;
                        end else begin
                            if (is_fast) begin
                                fast_phase_reg <= phase_inc;
                                skip_count_reg <= (phase_inc != 2'd0) ? SKIP_W'(2)
                                                                      : SKIP_W'(1);
                            end else if (is_slow) begin
                                skip_count_reg <= SKIP_W'(1);
                            end
                            state_reg <= (s_limited || is_slow) ? ST_TIME : ST_DEC;
                        end
                    end
                end
                ST_TIME: begin
                    if (tu_done) begin
                        if (limited_reg) begin
                            if (tu_flags.late_path) begin
                                // late: restart from now (release_reg holds now)
                                ref_time_reg    <= release_reg;
                                wait_budget_reg <= tu_flags.over_period ? '0 : tu_pml;
                                late_amount_reg <= (tu_flags.over_period && tu_flags.wrapped)
                                                   ? '0 : tu_late;
                            end else begin
                                // early: host resumes at the wait end
                                ref_time_reg    <= wait_end;
                                wait_budget_reg <= TIME_W'(period_reg);
                                late_amount_reg <= '0;
                            end
                        end else begin
                            wait_budget_reg <= tu_sum;
                        end
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    if (skip_count_reg != '0) begin
                        skip_count_reg <= skip_count_reg - 1'b1;
                        state_reg      <= ST_FIN;
                    end else if (skip_mode_reg != SKIP_OFF) begin
                        state_reg <= ST_EVAL;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_EVAL: begin
                    if (su_done) begin
                        skip_count_reg  <= skip_eval;
                        late_amount_reg <= '0;
                        state_reg       <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // register writes restart pacing
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PERIOD: begin
                        period_reg        <= cfg_data[PERIOD_W-1:0];
                        skip_count_reg    <= '0;
                        late_amount_reg   <= '0;
                        reset_pending_reg <= 1'b1;
                    end
                    REG_SKIP_MODE: begin
                        skip_mode_reg     <= cfg_data[MODE_W-1:0];
                        skip_count_reg    <= '0;
                        late_amount_reg   <= '0;
                        reset_pending_reg <= 1'b1;
                    end
                    REG_INTERLACED: begin
                        interlaced_reg    <= cfg_data[0];
                        skip_count_reg    <= '0;
                        late_amount_reg   <= '0;
                        reset_pending_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // per-item payload and output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            release_reg <= s_now_ticks;
            wait_reg    <= 1'b0;
            limited_reg <= s_limited;
            odd_reg     <= s_odd_field;
            // results that finish without the serial passes
            lat_reg     <= (reset_pending_reg) ? '0 : late_amount_reg;
        end
        if ((state_reg == ST_TIME) && tu_done && limited_reg && !tu_flags.late_path) begin
            release_reg <= wait_end;
            wait_reg    <= 1'b1;
        end
        if (state_reg == ST_DEC) begin
            lat_reg <= late_amount_reg;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_release_reg <= release_reg;
            m_wait_reg    <= wait_reg;
            m_skip_reg    <= skip_count_reg;
            m_lat_reg     <= lat_reg;
        end
    end

    fps_time_unit u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (tu_start),
        .slow      (is_slow),
        .now_in    (s_now_ticks),
        .ref_in    (ref_time_reg),
        .budget_in (wait_budget_reg),
        .period_in (period_reg),
        .done      (tu_done),
        .sum_out   (tu_sum),
        .late_out  (tu_late),
        .pml_out   (tu_pml),
        .end_out   (tu_end),
        .flags     (tu_flags)
    );

    fps_skip_unit u_skip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (su_start),
        .late_in   (late_amount_reg),
        .period_in (period_reg),
        .sel       (su_sel),
        .done      (su_done),
        .quo_out   (su_quo),
        .rem_out   (su_rem),
        .cmp       (su_cmp)
    );

    assign m_valid           = m_valid_reg;
    assign m_release_time    = m_release_reg;
    assign m_must_wait       = m_wait_reg;
    assign m_periods_to_skip = m_skip_reg;
    assign m_lateness        = m_lat_reg;

endmodule

/* rtl/fps_time_unit.sv */
// fps_time_unit: LSB-first bit-serial pass over the timer values: budget
// update, elapsed time, lateness, remaining budget and wait end. Uses fps_pkg.
module fps_time_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          slow,
    input  logic [fps_pkg::TIME_W-1:0]    now_in,
    input  logic [fps_pkg::TIME_W-1:0]    ref_in,
    input  logic [fps_pkg::TIME_W-1:0]    budget_in,
    input  logic [fps_pkg::PERIOD_W-1:0]  period_in,
    output logic                          done,
    output logic [fps_pkg::TIME_W-1:0]    sum_out,
    output logic [fps_pkg::TIME_W-1:0]    late_out,
    output logic [fps_pkg::TIME_W-1:0]    pml_out,
    output logic [fps_pkg::TIME_W-1:0]    end_out,
    output fps_pkg::fps_time_flags_t      flags
);
    import fps_pkg::*;

    logic             busy_reg, done_reg, slow_reg;
    logic [CNT_W-1:0] cnt_reg;

    // operand shift registers, LSB out first
    logic [TIME_W-1:0] now_sh_reg, ref_sh_reg, bud_sh_reg, per_sh_reg;
    // result shift registers, filled from the MSB end
    logic [TIME_W-1:0] sum_sh_reg, late_sh_reg, pml_sh_reg, end_sh_reg;

    // carries, borrows and running compares
    logic c_sum_reg, br_e_reg, gt_e_reg, br_l_reg, gt_lp_reg, br_p_reg, c_end_reg;
    logic c_sum_next, br_e_next, gt_e_next, br_l_next, gt_lp_next, br_p_next, c_end_next;

    logic p, b0, n, r, b, e, l, d, s;

    // one bit of every quantity per cycle
    always_comb begin
        p = per_sh_reg[0];
        b0 = bud_sh_reg[0];
        n = now_sh_reg[0];
        r = ref_sh_reg[0];
        // budget plus period in slow mode
        b = slow_reg ? (b0 ^ p ^ c_sum_reg) : b0;
        c_sum_next = (b0 & p) | (b0 & c_sum_reg) | (p & c_sum_reg);
        // elapsed = now - ref
        e = n ^ r ^ br_e_reg;
        br_e_next = (~n & r) | (~(n ^ r) & br_e_reg);
        gt_e_next = (e & ~b) | (~(e ^ b) & gt_e_reg);
        // late = elapsed - budget
        l = e ^ b ^ br_l_reg;
        br_l_next = (~e & b) | (~(e ^ b) & br_l_reg);
        gt_lp_next = (l & ~p) | (~(l ^ p) & gt_lp_reg);
        // period - late
        d = p ^ l ^ br_p_reg;
        br_p_next = (~p & l) | (~(p ^ l) & br_p_reg);
        // ref + budget + 1
        s = r ^ b ^ c_end_reg;
        c_end_next = (r & b) | (r & c_end_reg) | (b & c_end_reg);
    end

    // pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            slow_reg   <= slow;
            now_sh_reg <= now_in;
            ref_sh_reg <= ref_in;
            bud_sh_reg <= budget_in;
            per_sh_reg <= TIME_W'(period_in);
            c_sum_reg  <= 1'b0;
            br_e_reg   <= 1'b0;
            gt_e_reg   <= 1'b0;
            br_l_reg   <= 1'b0;
            gt_lp_reg  <= 1'b0;
            br_p_reg   <= 1'b0;
            c_end_reg  <= 1'b1;
        end else if (busy_reg) begin
            now_sh_reg  <= now_sh_reg >> 1;
            ref_sh_reg  <= ref_sh_reg >> 1;
            bud_sh_reg  <= bud_sh_reg >> 1;
            per_sh_reg  <= per_sh_reg >> 1;
            sum_sh_reg  <= {b, sum_sh_reg[TIME_W-1:1]};
            late_sh_reg <= {l, late_sh_reg[TIME_W-1:1]};
            pml_sh_reg  <= {d, pml_sh_reg[TIME_W-1:1]};
            end_sh_reg  <= {s, end_sh_reg[TIME_W-1:1]};
            c_sum_reg   <= c_sum_next;
            br_e_reg    <= br_e_next;
            gt_e_reg    <= gt_e_next;
            br_l_reg    <= br_l_next;
            gt_lp_reg   <= gt_lp_next;
            br_p_reg    <= br_p_next;
            c_end_reg   <= c_end_next;
        end
    end

    assign done     = done_reg;
    assign sum_out  = sum_sh_reg;
    assign late_out = late_sh_reg;
    assign pml_out  = pml_sh_reg;
    assign end_out  = end_sh_reg;

    always_comb begin
        flags.late_path   = gt_e_reg | br_e_reg;
        flags.wrapped     = br_e_reg;
        flags.over_period = gt_lp_reg;
        flags.end_wrap    = c_end_reg;
    end

endmodule

/* rtl/fps_skip_unit.sv */
// fps_skip_unit: MSB-first bit-serial restoring divide of lateness by period
// with a saturating quotient, plus a serial threshold compare. Uses fps_pkg.
module fps_skip_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fps_pkg::TIME_W-1:0]    late_in,
    input  logic [fps_pkg::PERIOD_W-1:0]  period_in,
    input  fps_pkg::fps_skip_sel_t        sel,
    output logic                          done,
    output logic [fps_pkg::Q_W-1:0]       quo_out,
    output logic [fps_pkg::PERIOD_W-1:0]  rem_out,
    output fps_pkg::fps_cmp_flags_t       cmp
);
    import fps_pkg::*;

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [TIME_W-1:0]   div_sh_reg, thr_sh_reg;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]      quo_reg, quo_next;
    logic                gt_reg, lt_reg;

    logic [PERIOD_W+2:0] to7;
    logic [PERIOD_W-1:0] timeout, thr;
    logic [PERIOD_W:0]   trial, per_ext, diff;
    logic                lb, tb, fits;

    // threshold: timeout is seven eighths of the period
    always_comb begin
        to7 = {period_in, 3'b000} - {3'b000, period_in};
        timeout = to7[PERIOD_W+2:3];
        if (sel.std_mode) begin
            thr = timeout;
        end else if (sel.interlaced) begin
            thr = timeout >> 3;
        end else begin
            thr = timeout >> 4;
        end
    end

    // one restoring step and one compare bit per cycle
    always_comb begin
        lb = div_sh_reg[TIME_W-1];
        tb = thr_sh_reg[TIME_W-1];
        trial = {rem_reg, lb};
        per_ext = {1'b0, period_in};
        diff = trial - per_ext;
        fits = (trial >= per_ext);
        rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        // once above the cap the true quotient only grows, so hold it
        if (quo_reg > Q_W'(MAX_SKIP)) begin
            quo_next = quo_reg;
        end else begin
            quo_next = {quo_reg[Q_W-2:0], fits};
        end
    end

    // pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            div_sh_reg <= late_in;
            thr_sh_reg <= TIME_W'(thr);
            rem_reg    <= '0;
            quo_reg    <= '0;
            gt_reg     <= 1'b0;
            lt_reg     <= 1'b0;
        end else if (busy_reg) begin
            div_sh_reg <= div_sh_reg << 1;
            thr_sh_reg <= thr_sh_reg << 1;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            // first differing bit decides the compare
            if (!gt_reg && !lt_reg) begin
                gt_reg <= lb & ~tb;
                lt_reg <= ~lb & tb;
            end
        end
    end

    assign done    = done_reg;
    assign quo_out = quo_reg;
    assign rem_out = rem_reg;

    always_comb begin
        cmp.ge = ~lt_reg;
        cmp.gt = gt_reg;
    end

endmodule

/* tb/tb_frame_pacer_with_skip.sv */
// Self-checking testbench for frame_pacer_with_skip: a directed table, then random
// phases, checked against a built-in model of the pacing and skip logic, or for
// rebase rows against table values. Depends on fps_pkg and the design RTL only.
module tb_frame_pacer_with_skip;
    import fps_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [SPEED_W-1:0]   SPD_NORMAL   = 2'd0;
    localparam logic [SPEED_W-1:0]   SPD_SPARE    = 2'd3;
    localparam logic [MODE_W-1:0]    SKIP_HALF    = 2'd2;
    localparam logic [MODE_W-1:0]    SKIP_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [31:0]          PMAX         = 32'hF_FFFF;
    localparam int                   HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              limited;
        logic [SPEED_W-1:0] speed;
        logic              odd;
    } frame_evt_t;

    typedef struct packed {
        logic [TIME_W-1:0] release_time;
        logic              must_wait;
        logic [SKIP_W-1:0] skips;
        logic [TIME_W-1:0] lateness;
    } pace_res_t;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        frame_evt_t              evt;
        bit                      has_exp;
        pace_res_t               exp;
    } plan_row_t;

    // Clock, reset and block inputs, all known from time zero
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [TIME_W-1:0]      s_now_ticks = '0;
    logic                   s_limited = 1'b0;
    logic [SPEED_W-1:0]     s_speed = '0;
    logic                   s_odd_field = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [TIME_W-1:0]      m_release_time;
    logic                   m_must_wait;
    logic [SKIP_W-1:0]      m_periods_to_skip;
    logic [TIME_W-1:0]      m_lateness;

    frame_pacer_with_skip dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_ticks       (s_now_ticks),
        .s_limited         (s_limited),
        .s_speed           (s_speed),
        .s_odd_field       (s_odd_field),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_release_time    (m_release_time),
        .m_must_wait       (m_must_wait),
        .m_periods_to_skip (m_periods_to_skip),
        .m_lateness        (m_lateness)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model copy of registers and pacing state
    logic [PERIOD_W-1:0] mdl_period = PERIOD_RESET;
    logic [MODE_W-1:0]   mdl_mode = SKIP_OFF;
    logic                mdl_ilace = 1'b0;
    logic [TIME_W-1:0]   ref_t = '0;
    logic [TIME_W-1:0]   budget = '0;
    logic [TIME_W-1:0]   late_amt = '0;
    logic [SKIP_W-1:0]   skips = '0;
    logic [1:0]          phase = '0;
    logic                rebase = 1'b1;

    pace_res_t  paces_due[$];
    plan_row_t  plan[$];
    int         mismatches = 0;
    bit         calm = 1'b0;
    int         fast_left = 0;
    logic       last_odd = 1'b0;
    bit         evt_has_exp = 1'b0;
    pace_res_t  evt_exp = '0;
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    frame_evt_t mon_evt;
    pace_res_t  mon_pred;
    pace_res_t  mon_want;

    // Register write: any known index restarts the reference and drops skipping
    function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PERIOD:     mdl_period = val;
            REG_SKIP_MODE:  mdl_mode = val[MODE_W-1:0];
            REG_INTERLACED: mdl_ilace = val[0];
            default:        return;
        endcase
        skips = '0;
        late_amt = '0;
        rebase = 1'b1;
    endfunction

    // Turn lateness into a count of periods to skip
    function automatic void judge_skip(logic odd);
        logic [31:0] tmo;
        logic [63:0] q;
        logic [31:0] rem;
        tmo = (32'(mdl_period) * 32'd7) >> 3;
        if (mdl_mode == SKIP_STD) begin
            if (late_amt >= tmo) begin
                if (mdl_period == 0) begin
                    q = '1;
                    rem = '0;
                end else begin
                    q = 64'(late_amt / 32'(mdl_period));
                    rem = late_amt % 32'(mdl_period);
                end
                if (mdl_ilace) begin
                    // pairs of fields, judged on even fields only
                    if (!odd) begin
                        if (q > MAX_SKIP)
                            q = MAX_SKIP;
                        else if (q[0])
                            q = q + 64'd1;
                        skips = q[SKIP_W-1:0];
                    end
                end else begin
                    // floor(q + 0.15) done exactly on the remainder
                    if (q >= MAX_SKIP)
                        q = MAX_SKIP - 1;
                    else if (64'(rem) * 64'd20 >= 64'(mdl_period) * 64'd17)
                        q = q + 64'd1;
                    if (q >= MAX_SKIP)
                        q = MAX_SKIP - 1;
                    skips = q[SKIP_W-1:0];
                end
            end
        end else begin
            if (mdl_ilace) begin
                if (late_amt > (tmo >> 3) && !odd)
                    skips = 3'd2;
            end else if (late_amt > (tmo >> 4)) begin
                skips = 3'd1;
            end
        end
        late_amt = '0;
    endfunction

    // Expected result of one frame-end event; updates the model state
    function automatic pace_res_t pace_frame(frame_evt_t e);
        logic [31:0] rel;
        logic        w;
        logic [31:0] elapsed;
        logic [32:0] fin;
        logic [31:0] lat;
        logic        nxt;
        rel = e.now;
        w = 1'b0;
        if (rebase) begin
            rebase = 1'b0;
            ref_t = e.now;
            late_amt = '0;
            budget = '0;
            return '{e.now, 1'b0, skips, 32'd0};
        end
        if (e.speed == SPD_FAST) begin
            phase = phase + 2'd1;
            nxt = (phase != 2'd0);
            if (skips != 0) begin
                skips = {2'b00, nxt};
                return '{e.now, 1'b0, skips, late_amt};
            end
            skips = 3'd1 + {2'b00, nxt};
        end else if (e.speed == SPD_SLOW) begin
            budget = budget + 32'(mdl_period);
            skips = 3'd1;
        end
        if (e.limited) begin
            elapsed = e.now - ref_t;
            if (elapsed > budget || e.now < ref_t) begin
                // late, or the timer wrapped
                late_amt = elapsed - budget;
                if (late_amt > 32'(mdl_period)) begin
                    budget = '0;
                    if (e.now < ref_t)
                        late_amt = '0;
                end else begin
                    budget = 32'(mdl_period) - late_amt;
                end
                ref_t = e.now;
            end else begin
                // early: wait out the budget, end clamps to zero past the wrap
                fin = {1'b0, ref_t} + {1'b0, budget} + 33'd1;
                rel = fin[32] ? 32'd0 : fin[31:0];
                w = 1'b1;
                budget = 32'(mdl_period);
                late_amt = '0;
                ref_t = rel;
            end
        end
        lat = late_amt;
        if (skips != 0)
            skips = skips - 3'd1;
        else if (mdl_mode != SKIP_OFF)
            judge_skip(e.odd);
        return '{rel, w, skips, lat};
    endfunction

    // Random event aimed at a chosen lateness against the model reference
    function automatic frame_evt_t make_evt();
        frame_evt_t  e;
        logic [31:0] p;
        logic [31:0] tmo;
        logic [31:0] lat_t;
        logic [31:0] r17;
        int unsigned pick;
        int unsigned k;
        p = (mdl_period == 0) ? 32'd1 : 32'(mdl_period);
        tmo = (p * 32'd7) >> 3;
        r17 = (p * 32'd17 + 32'd19) / 32'd20;
        pick = $urandom_range(0, 99);
        lat_t = 32'd1;
        if (rebase) begin
            if (pick < 50)
                e.now = $urandom;
            else if (pick < 75)
                e.now = 32'hFFFF_FFFF - $urandom_range(0, 8 * p);
            else
                e.now = $urandom_range(0, 1000);
        end else if (pick < 28) begin
            e.now = ref_t + $urandom_range(0, budget);
        end else if (pick < 82) begin
            if (pick < 50) begin
                lat_t = $urandom_range(1, p);
            end else if (pick < 68) begin
                k = $urandom_range(1, 6);
                lat_t = k * p + $urandom_range(0, p - 1);
            end else begin
                // threshold edges
                k = $urandom_range(0, 3);
                case ($urandom_range(0, 7))
                    0: lat_t = p;
                    1: lat_t = p + 32'd1;
                    2: lat_t = tmo - 32'd1;
                    3: lat_t = tmo;
                    4: lat_t = tmo >> 3;
                    5: lat_t = (tmo >> 3) + 32'd1;
                    6: lat_t = (tmo >> 4) + 32'd1;
                    default: lat_t = k * p + r17 - $urandom_range(0, 1);
                endcase
            end
            e.now = ref_t + budget + lat_t;
        end else if (pick < 92) begin
            e.now = $urandom;
        end else begin
            e.now = ref_t - $urandom_range(1, 4 * p);
        end
        e.limited = ($urandom_range(0, 99) < 88);
        if (fast_left > 0) begin
            e.speed = SPD_FAST;
            fast_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 66) begin
                e.speed = SPD_NORMAL;
            end else if (pick < 78) begin
                e.speed = SPD_SLOW;
            end else if (pick < 95) begin
                e.speed = SPD_FAST;
                fast_left = $urandom_range(0, 7);
            end else begin
                e.speed = SPD_SPARE;
            end
        end
        if (mdl_ilace && $urandom_range(0, 99) < 90)
            e.odd = ~last_odd;
        else
            e.odd = $urandom_range(0, 1);
        last_odd = e.odd;
        return e;
    endfunction

    function automatic void add_evt(logic [31:0] now, logic lim, logic [1:0] spd, logic odd);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx = '0;
        row.data = '0;
        row.evt = '{now, lim, spd, odd};
        row.has_exp = 1'b0;
        row.exp = '0;
        plan.push_back(row);
    endfunction

    // Event right after reset or a register write: takes the time as reference
    function automatic void add_rebase(logic [31:0] now);
        add_evt(now, 1'b1, SPD_NORMAL, 1'b0);
        plan[$].has_exp = 1'b1;
        plan[$].exp = '{now, 1'b0, 3'd0, 32'd0};
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = val;
        row.evt = '0;
        row.has_exp = 1'b0;
        row.exp = '0;
        plan.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one event; returns at the edge where it is taken
    task automatic send_item(input bit rnd, input plan_row_t row);
        frame_evt_t e;
        int         gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 24)
            gap++;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if (rnd) begin
            e = make_evt();
            evt_has_exp = 1'b0;
            evt_exp = '0;
        end else begin
            e = row.evt;
            evt_has_exp = row.has_exp;
            evt_exp = row.exp;
        end
        s_valid <= 1'b1;
        s_now_ticks <= e.now;
        s_limited <= e.limited;
        s_speed <= e.speed;
        s_odd_field <= e.odd;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected result is in
    task automatic drain(input int settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (paces_due.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    // Predict on every taken event, check every taken result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                load_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                mon_evt = '{s_now_ticks, s_limited, s_speed, s_odd_field};
                mon_pred = pace_frame(mon_evt);
                paces_due.push_back(evt_has_exp ? evt_exp : mon_pred);
            end
            if (m_valid && m_ready) begin
                if (paces_due.size() == 0) begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end else begin
                    mon_want = paces_due.pop_front();
                    check_field("release_time", mon_want.release_time, m_release_time);
                    check_field("must_wait", 32'(mon_want.must_wait), 32'(m_must_wait));
                    check_field("periods_to_skip", 32'(mon_want.skips), 32'(m_periods_to_skip));
                    check_field("lateness", mon_want.lateness, m_lateness);
                end
            end
        end
    end

    initial begin
        int          ph;
        int          i;
        logic [19:0] per;
        logic [1:0]  md;
        logic        il;
        plan_row_t   blank;
        logic [31:0] t0;

        blank = '{1'b0, '0, '0, '0, 1'b0, '0};

        // Directed table, reset config: period 16, no skipping
        add_rebase(32'd1000);
        add_evt(32'd1005, 1'b1, SPD_NORMAL, 1'b0);         // late, budget shortened
        add_evt(32'd1010, 1'b1, SPD_NORMAL, 1'b0);         // early, waits
        add_evt(32'd1017, 1'b0, SPD_NORMAL, 1'b1);         // no limit applied
        add_evt(32'd0, 1'b1, SPD_NORMAL, 1'b0);            // timer wrapped
        add_evt(32'd20, 1'b1, SPD_SLOW, 1'b0);
        add_evt(32'd40, 1'b1, SPD_SPARE, 1'b1);            // unused speed code
        // longest period, wait end running past the wrap point
        add_cfg(REG_PERIOD, PMAX[19:0]);
        add_rebase(32'hFFFF_FFF0);
        add_evt(32'hFFFF_FFF0, 1'b1, SPD_NORMAL, 1'b0);
        add_evt(32'hFFFF_FFF1, 1'b1, SPD_NORMAL, 1'b0);
        // standard skipping, then fast items while skipping
        add_cfg(REG_SKIP_MODE, 20'(SKIP_STD));
        add_rebase(32'd5000);
        t0 = 32'd5000 + 3 * PMAX + PMAX / 2;
        add_evt(t0, 1'b1, SPD_NORMAL, 1'b0);
        for (i = 1; i <= 5; i++)
            add_evt(t0 + 32'(i * 10), 1'b1, SPD_FAST, 1'b0);
        // interlaced pairs on an even field
        add_cfg(REG_INTERLACED, 20'd1);
        add_rebase(32'h0001_0000);
        add_evt(32'h0001_0000 + 3 * PMAX + 32'd10, 1'b1, SPD_NORMAL, 1'b0);
        // half mode, interlaced
        add_cfg(REG_SKIP_MODE, 20'(SKIP_HALF));
        add_rebase(32'h8000_0000);
        add_evt(32'h8000_0000 + PMAX / 4, 1'b1, SPD_NORMAL, 1'b0);
        // unused skip mode acts as half, progressive
        add_cfg(REG_SKIP_MODE, 20'(SKIP_SPARE));
        add_cfg(REG_INTERLACED, 20'd0);
        add_rebase(32'h7FFF_FFFF);
        add_evt(32'h7FFF_FFFF + PMAX / 8, 1'b1, SPD_NORMAL, 1'b1);
        // zero period: quotient saturates
        add_cfg(REG_PERIOD, 20'd0);
        add_cfg(REG_SKIP_MODE, 20'(SKIP_STD));
        add_rebase(32'd0);
        add_evt(32'd50, 1'b1, SPD_NORMAL, 1'b0);
        // write to an index with no register: state carries on
        add_cfg(REG_UNUSED, PMAX[19:0]);
        add_evt(32'd60, 1'b1, SPD_NORMAL, 1'b0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[j]) begin
            if (plan[j].is_cfg) begin
                drain(10);
                write_reg(plan[j].idx, plan[j].data);
            end else begin
                send_item(1'b0, plan[j]);
            end
        end
        drain(10);

        // Random phases, each with its own register setting
        for (ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                per = 20'd1;
            end else if (ph == 1) begin
                per = PMAX[19:0];
            end else begin
                case ($urandom_range(0, 7))
                    0: per = 20'd2;
                    1: per = 20'd3;
                    2: per = $urandom_range(4, 40);
                    3: per = $urandom_range(41, 2000);
                    4: per = $urandom_range(2001, 100000);
                    5: per = $urandom_range(2001, 100000);
                    6: per = $urandom_range(1, PMAX);
                    default: per = PERIOD_RESET;
                endcase
            end
            md = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
            il = (ph < 8) ? 1'((ph / 4) % 2) : 1'($urandom_range(0, 1));
            write_reg(REG_PERIOD, per);
            write_reg(REG_SKIP_MODE, (20'($urandom) & ~20'h3) | 20'(md));
            write_reg(REG_INTERLACED, (20'($urandom) & ~20'h1) | 20'(il));
            calm = (ph == 6);
            for (i = 0; i < 115; i++) begin
                if (ph == 3 && i == 40)
                    hold_asks++;
                if (ph == 5 && i == 57)
                    drain(0);
                send_item(1'b1, blank);
            end
            drain(10);
        end
        calm = 1'b0;
        drain(80);

        if (mismatches == 0 && paces_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
